// File: rtl/core/wnll_pkg.sv
// Shared package for the weighted NLL loss reducer: widths, fixed-point
// constants, codes, FSM states and the command/status structs.
// No dependencies; wnll_ctrl, wnll_datapath and the top level import it.
`timescale 1ns / 1ps

package wnll_pkg;

   // Sizing of the block.
   localparam int MAX_CLASSES = 1024;
   localparam int FRAC_BITS   = 24;
   localparam int ACC_WIDTH   = 48;

   // Fixed field widths of the channels and registers.
   localparam int ACTION_W  = 2;
   localparam int WIDX_W    = 10;
   localparam int WEIGHT_W  = 32;
   localparam int LABEL_W   = 16;
   localparam int SCORE_W   = 32;
   localparam int KIND_W    = 2;
   localparam int OUT_WIDTH = 48;
   localparam int MODE_W    = 2;
   localparam int CLASSES_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Derived sizes.
   localparam int CLS_IDX_W = $clog2(MAX_CLASSES);
   localparam int PROD_W    = SCORE_W + WEIGHT_W;
   localparam int SH_W      = PROD_W - FRAC_BITS;
   localparam int DIV_W     = ACC_WIDTH + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(64'd1 << FRAC_BITS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_WEIGHT   = 2'd0,
      ACT_SAMPLE   = 2'd1,
      ACT_FINISH   = 2'd2,
      ACT_RESERVED = 2'd3
   } action_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE     = 2'd0,
      MODE_SUM      = 2'd1,
      MODE_MEAN     = 2'd2,
      MODE_RESERVED = 2'd3
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOSS      = 2'd0,
      KIND_BATCH     = 2'd1,
      KIND_RANGE_ERR = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE        = 2'd0,
      CSR_IGNORE      = 2'd1,
      CSR_CLASSES     = 2'd2,
      CSR_USE_WEIGHTS = 2'd3
   } csr_index_type;

   localparam mode_type                 MODE_RESET     = MODE_MEAN;
   localparam logic signed [LABEL_W-1:0] IGNORE_RESET  = -16'sd100;
   localparam logic [CLASSES_W-1:0]     CLASSES_RESET  = 11'd1024;
   localparam logic                     USE_W_RESET    = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_ACC,
      ST_DIV,
      ST_DIV_ROUND,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ERR,
      SEL_LOSS,
      SEL_BATCH
   } res_sel_type;

   typedef struct packed {
      logic        wr_weight;
      logic        capture;
      logic        finish;
      logic        mul;
      logic        round;
      logic        acc;
      logic        div_step;
      logic        div_round;
      logic        load_out;
      res_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     ignored;
      logic     out_of_range;
      logic     tw_nonzero;
      logic     div_last;
      logic     out_free;
      mode_type mode;
   } dp_status_type;

endpackage

// File: rtl/core/wnll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wnll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/wnll_ctrl.sv
// Controller state machine of the NLL loss reducer: sequences capture,
// multiply, round, accumulate, divide and result load. Uses wnll_pkg.
`timescale 1ns / 1ps

module wnll_ctrl
   import wnll_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [ACTION_W-1:0] req_action,
   output logic                req_ready,
   input  dp_status_type       status,
   output ctrl_cmd_type        cmd
);

   state_type   state_ff, state_in;
   res_sel_type sel_ff, sel_in;
   logic        accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= SEL_ZERO;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // Next state and result selection.
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_SAMPLE: begin
                     if (status.ignored) begin
                        if (status.mode == MODE_NONE) begin
                           sel_in   = SEL_ZERO;
                           state_in = ST_EMIT;
                        end
                     end else if (status.out_of_range) begin
                        sel_in   = SEL_ERR;
                        state_in = ST_EMIT;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  ACT_FINISH: begin
                     if (status.mode == MODE_NONE) begin
                        state_in = ST_IDLE;
                     end else if (status.mode == MODE_MEAN && status.tw_nonzero) begin
                        state_in = ST_DIV;
                     end else begin
                        sel_in   = SEL_BATCH;
                        state_in = ST_EMIT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL: state_in = ST_ROUND;
         ST_ROUND: begin
            if (status.mode == MODE_NONE) begin
               sel_in   = SEL_LOSS;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: state_in = ST_IDLE;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_DIV_ROUND;
            end
         end
         ST_DIV_ROUND: begin
            sel_in   = SEL_BATCH;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd           = '0;
      cmd.sel       = sel_ff;
      cmd.wr_weight = accept && (req_action == ACT_WEIGHT);
      cmd.capture   = accept && (req_action == ACT_SAMPLE);
      cmd.finish    = accept && (req_action == ACT_FINISH);
      unique case (state_ff)
         ST_MUL:       cmd.mul       = 1'b1;
         ST_ROUND:     cmd.round     = 1'b1;
         ST_ACC:       cmd.acc       = 1'b1;
         ST_DIV:       cmd.div_step  = 1'b1;
         ST_DIV_ROUND: cmd.div_round = 1'b1;
         ST_EMIT:      cmd.load_out  = status.out_free;
         default:      cmd.load_out  = 1'b0;
      endcase
   end

endmodule

// File: rtl/core/wnll_datapath.sv
// Datapath of the NLL loss reducer: configuration registers, class weight
// RAM, multiplier, rounding, saturating accumulators, restoring divider and
// output register. Uses wnll_pkg and wnll_ram.
`timescale 1ns / 1ps

module wnll_datapath
   import wnll_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic [WIDX_W-1:0]           req_weight_index,
   input  logic signed [WEIGHT_W-1:0]  req_weight_value,
   input  logic signed [LABEL_W-1:0]   req_label,
   input  logic signed [SCORE_W-1:0]   req_score,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [KIND_W-1:0]           rsp_kind,
   output logic signed [OUT_WIDTH-1:0] rsp_loss,
   output logic signed [OUT_WIDTH-1:0] rsp_batch_weight,
   input  ctrl_cmd_type                cmd,
   output dp_status_type               status
);

   localparam int RW = (SH_W > ACC_WIDTH) ? SH_W : ACC_WIDTH;
   localparam int OW = (ACC_WIDTH > OUT_WIDTH) ? ACC_WIDTH : OUT_WIDTH;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic signed [RW-1:0] ACC_MAX_R =
      {{(RW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] ACC_MIN_R = ~ACC_MAX_R;
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = ~OUT_MAX;
   localparam logic signed [OW-1:0] OUT_MAX_W =
      {{(OW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OW-1:0] OUT_MIN_W = ~OUT_MAX_W;
   localparam logic [PROD_W-1:0] RND_ADD =
      PROD_W'((64'd1 << (FRAC_BITS-1)) + 64'd1);
   localparam logic [DIV_W:0] LIM_POS =
      {{(DIV_W-ACC_WIDTH+2){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [DIV_W:0] LIM_NEG =
      {{(DIV_W-ACC_WIDTH+1){1'b0}}, 1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W-1);

   function automatic logic signed [ACC_WIDTH-1:0] clamp_acc(
      input logic signed [SH_W-1:0] v
   );
      logic signed [RW-1:0] x;
      x = RW'(v);
      if (x > ACC_MAX_R) return ACC_MAX;
      if (x < ACC_MIN_R) return ACC_MIN;
      return ACC_WIDTH'(x);
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] clamp_out(
      input logic signed [ACC_WIDTH-1:0] v
   );
      logic signed [OW-1:0] x;
      x = OW'(v);
      if (x > OUT_MAX_W) return OUT_MAX;
      if (x < OUT_MIN_W) return OUT_MIN;
      return OUT_WIDTH'(x);
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] a,
      input logic signed [ACC_WIDTH-1:0] b
   );
      logic signed [ACC_WIDTH:0] s;
      s = (ACC_WIDTH+1)'(a) + (ACC_WIDTH+1)'(b);
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) return s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      return s[ACC_WIDTH-1:0];
   endfunction

   function automatic logic [ACC_WIDTH-1:0] magnitude(
      input logic signed [ACC_WIDTH-1:0] v
   );
      return v[ACC_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   // Configuration registers.
   mode_type                  mode_ff;
   logic signed [LABEL_W-1:0] ignore_ff;
   logic [CLASSES_W-1:0]      classes_ff;
   logic                      use_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         ignore_ff  <= IGNORE_RESET;
         classes_ff <= CLASSES_RESET;
         use_w_ff   <= USE_W_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:        mode_ff    <= mode_type'(csr_wdata[MODE_W-1:0]);
            CSR_IGNORE:      ignore_ff  <= csr_wdata[LABEL_W-1:0];
            CSR_CLASSES:     classes_ff <= csr_wdata[CLASSES_W-1:0];
            CSR_USE_WEIGHTS: use_w_ff   <= csr_wdata[0];
         endcase
      end
   end

   // Label classification on the incoming beat.
   logic [LABEL_W-1:0] label_u;
   assign label_u = req_label[LABEL_W-1:0];

   assign status.ignored      = (req_label == ignore_ff);
   assign status.out_of_range = req_label[LABEL_W-1]
                              || (32'(label_u) >= 32'(classes_ff))
                              || (32'(label_u) >= MAX_CLASSES);
   assign status.mode         = mode_ff;

   // Class weight memory.
   logic                wr_en;
   logic [WEIGHT_W-1:0] rd_data;

   assign wr_en = cmd.wr_weight && (32'(req_weight_index) < MAX_CLASSES);

   wnll_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (MAX_CLASSES)
   ) u_weights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (CLS_IDX_W'(req_weight_index)),
      .wr_data (req_weight_value),
      .rd_en   (cmd.capture),
      .rd_addr (CLS_IDX_W'(label_u)),
      .rd_data (rd_data)
   );

   // Multiply and round.
   logic signed [SCORE_W-1:0]   score_ff;
   logic signed [WEIGHT_W-1:0]  w_ff, w_sel;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]           rnd_sum;
   logic signed [SH_W-1:0]      shifted;
   logic signed [ACC_WIDTH-1:0] loss_ff;

   assign w_sel   = use_w_ff ? $signed(rd_data) : WEIGHT_ONE;
   assign prod_in = score_ff * w_sel;
   // Negate and add half an LSB in one adder: ~p + 1 + half.
   assign rnd_sum = ~prod_ff + RND_ADD;
   assign shifted = rnd_sum[PROD_W-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         score_ff <= req_score;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         w_ff    <= w_sel;
      end
      if (cmd.round) begin
         loss_ff <= clamp_acc(shifted);
      end
   end

   // Accumulators and batch snapshot.
   logic signed [ACC_WIDTH-1:0] loss_sum_ff, weight_sum_ff;
   logic signed [ACC_WIDTH-1:0] snap_loss_ff, snap_tw_ff, mean_res;

   assign status.tw_nonzero = (weight_sum_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_sum_ff   <= '0;
         weight_sum_ff <= '0;
      end else if (cmd.finish) begin
         loss_sum_ff   <= '0;
         weight_sum_ff <= '0;
      end else if (cmd.acc) begin
         loss_sum_ff   <= sat_add(loss_sum_ff, loss_ff);
         weight_sum_ff <= sat_add(weight_sum_ff, ACC_WIDTH'(w_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         snap_loss_ff <= loss_sum_ff;
         snap_tw_ff   <= weight_sum_ff;
      end else if (cmd.div_round) begin
         snap_loss_ff <= mean_res;
      end
   end

   // Restoring divider, one quotient bit per cycle. The numerator register
   // shifts out its top bit into the remainder and takes quotient bits in.
   logic [DIV_W-1:0]     div_num_ff;
   logic [ACC_WIDTH-1:0] div_den_ff, div_rem_ff, div_rem_in;
   logic                 div_neg_ff, div_ge;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [ACC_WIDTH:0]   div_shift, div_diff, div_two_r;
   logic                 div_bump;
   logic [DIV_W:0]       div_qr, div_lim, div_qs;
   logic [ACC_WIDTH-1:0] div_mag;

   assign div_shift  = {div_rem_ff, div_num_ff[DIV_W-1]};
   assign div_diff   = div_shift - {1'b0, div_den_ff};
   assign div_ge     = (div_shift >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? div_diff[ACC_WIDTH-1:0] : div_shift[ACC_WIDTH-1:0];
   assign status.div_last = (div_cnt_ff == DIV_LAST);

   // Round half away from zero on the magnitude, then saturate and sign.
   assign div_two_r = {div_rem_ff, 1'b0};
   assign div_bump  = (div_two_r >= {1'b0, div_den_ff});
   assign div_qr    = {1'b0, div_num_ff} + (DIV_W+1)'(div_bump);
   assign div_lim   = div_neg_ff ? LIM_NEG : LIM_POS;
   assign div_qs    = (div_qr > div_lim) ? div_lim : div_qr;
   assign div_mag   = div_qs[ACC_WIDTH-1:0];
   assign mean_res  = div_neg_ff ? (~div_mag + 1'b1) : div_mag;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         div_num_ff <= {magnitude(loss_sum_ff), {FRAC_BITS{1'b0}}};
         div_den_ff <= magnitude(weight_sum_ff);
         div_rem_ff <= '0;
         div_neg_ff <= loss_sum_ff[ACC_WIDTH-1] ^ weight_sum_ff[ACC_WIDTH-1];
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_num_ff <= {div_num_ff[DIV_W-2:0], div_ge};
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Output register.
   logic                        out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]           out_kind_ff, res_kind;
   logic signed [OUT_WIDTH-1:0] out_loss_ff, out_tw_ff, res_loss, res_tw;

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      res_kind = KIND_LOSS;
      res_loss = '0;
      res_tw   = '0;
      case (cmd.sel)
         SEL_ZERO: res_kind = KIND_LOSS;
         SEL_ERR:  res_kind = KIND_RANGE_ERR;
         SEL_LOSS: begin
            res_kind = KIND_LOSS;
            res_loss = clamp_out(loss_ff);
         end
         SEL_BATCH: begin
            res_kind = KIND_BATCH;
            res_loss = clamp_out(snap_loss_ff);
            res_tw   = clamp_out(snap_tw_ff);
         end
         default: res_kind = KIND_LOSS;
      endcase
   end

   assign out_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_kind_ff <= res_kind;
         out_loss_ff <= res_loss;
         out_tw_ff   <= res_tw;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_loss         = out_loss_ff;
   assign rsp_batch_weight = out_tw_ff;

endmodule

// File: rtl/core/weighted_nll_loss_reducer.sv
// Top level of the weighted negative log-likelihood loss reducer.
// Depends on wnll_pkg, wnll_ctrl, wnll_datapath and wnll_ram.
`timescale 1ns / 1ps

// The block takes one beat at a time on the req channel and holds req_ready
// low while that beat is in work. A class weight write (action 0) or a
// reserved action completes on accept. A sample passes through weight RAM
// read, one 32 by 32 multiply, negate and round, then either the saturating
// accumulate (sum and mean modes) or the load of the output register (mode
// none). Ignored and out-of-range samples skip the arithmetic and go
// straight to the output load when they produce a result. A finish beat in
// sum mode, or in mean mode with a zero total weight, goes straight to the
// output load; in mean mode with a nonzero total weight it first runs the
// restoring divider, one quotient bit per cycle, and rounds the quotient.
// Results sit in an output register, so a new beat is accepted while a
// result still waits on rsp; a beat that itself produces a result waits only
// if that register is still full. All values are signed fixed point with
// FRAC_BITS fraction bits; losses and sums saturate. The weight RAM has no
// reset: reading a class weight that was never written returns whatever the
// memory holds. The user must write configuration on the csr port only while
// the block is idle; the block itself does not enforce this.
module weighted_nll_loss_reducer
   import wnll_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Configuration write port.
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   // Request channel.
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ACTION_W-1:0]         req_action,
   input  logic [WIDX_W-1:0]           req_weight_index,
   input  logic signed [WEIGHT_W-1:0]  req_weight_value,
   input  logic signed [LABEL_W-1:0]   req_label,
   input  logic signed [SCORE_W-1:0]   req_score,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [KIND_W-1:0]           rsp_kind,
   output logic signed [OUT_WIDTH-1:0] rsp_loss,
   output logic signed [OUT_WIDTH-1:0] rsp_batch_weight
);

   // The controller sees only the handshake and action code of the request
   // beat; everything it needs from the data side comes back as status.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   wnll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the configuration, the weight RAM, the arithmetic
   // and the output register that parts the result channel from the work.
   wnll_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_label        (req_label),
      .req_score        (req_score),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_loss         (rsp_loss),
      .rsp_batch_weight (rsp_batch_weight),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
